// File: sv/mpbq_pkg.sv
// Package for the multichannel peaking biquad unit.
// Holds fixed widths, register codes, reset values and the sequencer state type.
// No dependencies.
package mpbq_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 24;
    localparam int YSTORE_W   = 32;
    localparam int CH_FIELD_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 2 * COEF_W;
    // five products of up to 2^62 each, plus sign
    localparam int ACC_W      = PROD_W + 4;
    localparam int STEP_W     = 3;

    localparam logic [STEP_W-1:0] FILT_LAST = STEP_W'(4);
    localparam logic [STEP_W-1:0] MIX_LAST  = STEP_W'(1);

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A0  = 3'd0,
        REG_A1  = 3'd1,
        REG_A2  = 3'd2,
        REG_B1  = 3'd3,
        REG_B2  = 3'd4,
        REG_WET = 3'd5,
        REG_DRY = 3'd6
    } t_reg_idx;

    // tap order inside the filter pass
    typedef enum logic [STEP_W-1:0] {
        TAP_X0 = 3'd0,
        TAP_X1 = 3'd1,
        TAP_X2 = 3'd2,
        TAP_Y1 = 3'd3,
        TAP_Y2 = 3'd4
    } t_tap;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FILT,
        S_FEND,
        S_YSAT,
        S_MIX,
        S_MEND,
        S_OSAT
    } t_state;

endpackage

// File: sv/multichannel_peaking_biquad_unit.sv
// Multichannel direct-form-I biquad with wet/dry mix, per-channel delay state in RAM.
// Depends on mpbq_pkg and mpbq_ram.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------------
//  input     | in        | i_in_valid / o_in_ready    | i_sample_in, i_channel
//  output    | out       | o_out_valid / i_out_ready  | o_sample_out, o_out_channel
//  config    | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// One word goes from accept to result register through the state RAM read, seven
// passes through the single 32x32 multiplier (five filter taps, two mix taps), drains
// and rounding steps. The next word is taken only once the result is in the
// output register, so a new word never enters before the last one is through.
// A result that is not taken stalls the sequencer in its final step only.
// Reset is synchronous; per-channel valid bits make every channel read as zero after it.
module multichannel_peaking_biquad_unit #(
    parameter int CHANNELS    = mpbq_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mpbq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    input  logic [mpbq_pkg::CH_FIELD_W-1:0]       i_channel,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    output logic [mpbq_pkg::CH_FIELD_W-1:0]       o_out_channel,
    input  logic                                  i_cfg_we,
    input  logic [mpbq_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mpbq_pkg::COEF_W-1:0]           i_cfg_wdata
);

    import mpbq_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_W = 2 * SAMPLE_BITS + 2 * YSTORE_W;
    localparam int Q_W   = ACC_W - COEF_FRAC;
    localparam int MOD_W = 9;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [YSTORE_W-1:0]    Y_MAX   = {1'b0, {(YSTORE_W-1){1'b1}}};
    localparam logic signed [YSTORE_W-1:0]    Y_MIN   = {1'b1, {(YSTORE_W-1){1'b0}}};

    // coefficients
    logic signed [COEF_W-1:0] r_a0, r_a1, r_a2, r_b1, r_b2, r_wet, r_dry;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;

    logic signed [SAMPLE_BITS-1:0] r_x, r_x1, r_x2;
    logic signed [YSTORE_W-1:0]    r_y1, r_y2, r_y;
    logic [CH_W-1:0]               r_idx;
    logic [CH_FIELD_W-1:0]         r_ch;
    logic [CHANNELS-1:0]           r_vld;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv, r_psub;
    logic signed [ACC_W-1:0]  r_acc;

    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic [CH_FIELD_W-1:0]         r_out_ch;

    logic                     w_accept;
    logic                     w_ram_re, w_ram_we;
    logic                     w_mul_en, w_mul_sub;
    logic                     w_out_load;
    logic [CH_W-1:0]          w_idx;
    logic [MOD_W-1:0]         w_mod;
    logic [MEM_W-1:0]         w_rdata, w_wdata;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [COEF_W-1:0] w_opd;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [Q_W-1:0]    w_q;
    logic signed [YSTORE_W-1:0]    w_y;
    logic signed [SAMPLE_BITS-1:0] w_r;
    logic                     w_y_fits, w_r_fits;

    assign w_accept = i_in_valid && o_in_ready;

    // channel field modulo CHANNELS, by repeated subtraction on a 3-bit value
    always_comb begin
        w_mod = MOD_W'(i_channel);
        for (int k = 0; k < 8; k++) begin
            if (w_mod >= MOD_W'(CHANNELS)) begin
                w_mod = w_mod - MOD_W'(CHANNELS);
            end
        end
    end
    assign w_idx = w_mod[CH_W-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0  <= COEF_ONE;
            r_a1  <= COEF_ZERO;
            r_a2  <= COEF_ZERO;
            r_b1  <= COEF_ZERO;
            r_b2  <= COEF_ZERO;
            r_wet <= COEF_ZERO;
            r_dry <= COEF_ONE;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_A0:  r_a0  <= i_cfg_wdata;
                REG_A1:  r_a1  <= i_cfg_wdata;
                REG_A2:  r_a2  <= i_cfg_wdata;
                REG_B1:  r_b1  <= i_cfg_wdata;
                REG_B2:  r_b2  <= i_cfg_wdata;
                REG_WET: r_wet <= i_cfg_wdata;
                REG_DRY: r_dry <= i_cfg_wdata;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_READ;
            S_READ:  n_state = S_FILT;
            S_FILT:  if (r_step == FILT_LAST) n_state = S_FEND;
            S_FEND:  n_state = S_YSAT;
            S_YSAT:  n_state = S_MIX;
            S_MIX:   if (r_step == MIX_LAST) n_state = S_MEND;
            S_MEND:  n_state = S_OSAT;
            S_OSAT:  if (!r_out_vld || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_ram_re   = w_accept;
        w_ram_we   = (r_state == S_YSAT);
        w_mul_en   = (r_state == S_FILT) || (r_state == S_MIX);
        w_mul_sub  = (r_state == S_FILT) && (r_step >= TAP_Y1);
        w_out_load = (r_state == S_OSAT) && (!r_out_vld || i_out_ready);
    end

    // multiplier operand select
    always_comb begin
        w_coef = '0;
        w_opd  = '0;
        if (r_state == S_FILT) begin
            unique case (t_tap'(r_step))
                TAP_X0: begin w_coef = r_a0; w_opd = COEF_W'(r_x);  end
                TAP_X1: begin w_coef = r_a1; w_opd = COEF_W'(r_x1); end
                TAP_X2: begin w_coef = r_a2; w_opd = COEF_W'(r_x2); end
                TAP_Y1: begin w_coef = r_b1; w_opd = r_y1;          end
                TAP_Y2: begin w_coef = r_b2; w_opd = r_y2;          end
                default: ;
            endcase
        end else if (r_state == S_MIX) begin
            if (r_step == MIX_LAST) begin
                w_coef = r_wet;
                w_opd  = r_y;
            end else begin
                w_coef = r_dry;
                w_opd  = COEF_W'(r_x);
            end
        end
    end

    // round half up, then saturate
    assign w_rnd    = r_acc + RND_HALF;
    assign w_q      = w_rnd[ACC_W-1:COEF_FRAC];
    assign w_y_fits = (&w_q[Q_W-1:YSTORE_W-1]) || !(|w_q[Q_W-1:YSTORE_W-1]);
    assign w_r_fits = (&w_q[Q_W-1:SAMPLE_BITS-1]) || !(|w_q[Q_W-1:SAMPLE_BITS-1]);
    assign w_y = w_y_fits ? w_q[YSTORE_W-1:0] : (w_q[Q_W-1] ? Y_MIN : Y_MAX);
    assign w_r = w_r_fits ? w_q[SAMPLE_BITS-1:0] : (w_q[Q_W-1] ? OUT_MIN : OUT_MAX);

    assign w_wdata = {r_x, r_x1, w_y, r_y1};

    mpbq_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_vld     <= '0;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= w_mul_en;
            if (w_mul_en && n_state == r_state) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (w_ram_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= i_sample_in;
            r_ch  <= i_channel;
            r_idx <= w_idx;
        end
        if (r_state == S_READ) begin
            if (r_vld[r_idx]) begin
                {r_x1, r_x2, r_y1, r_y2} <= w_rdata;
            end else begin
                {r_x1, r_x2, r_y1, r_y2} <= '0;
            end
        end
        r_prod <= w_coef * w_opd;
        r_psub <= w_mul_sub;
        if (w_accept || r_state == S_YSAT) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_psub ? r_acc - ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_YSAT) begin
            r_y <= w_y;
        end
        if (w_out_load) begin
            r_sample_out <= w_r;
            r_out_ch     <= r_ch;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_sample_out  = r_sample_out;
    assign o_out_channel = r_out_ch;

    // a new word only enters the RAM read step
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ))
        else $error("accepted word did not start a state read");

    // write-back never overlaps a read of the state RAM
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("state RAM read and write in the same cycle");

    // no product still pending when the filter sum is rounded
    a_ysat_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YSAT) |-> !r_pv)
        else $error("filter sum rounded with a product in flight");

    // a pending product comes only from a multiply step
    a_pv_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_state == S_FILT || r_state == S_MIX))
        else $error("product valid without a multiply step");

    // the output register fills only from the final step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_OSAT))
        else $error("result register loaded outside the final step");

endmodule

// File: sv/mpbq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mpbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
